// ===== rtl/utf8cjk_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8cjk_pkg
// Shared types, constants and character-class helpers for the UTF-8 CJK
// ratio classifier.
// ----------------------------------------------------------------------------
package utf8cjk_pkg;

    // counter sizing
    localparam int COUNT_BITS = 24;
    localparam int PROD_BITS  = COUNT_BITS + 4;
    localparam int CP_BITS    = 21;

    // configuration register indexes
    localparam logic [7:0] CFG_EARLY_MIN = 8'd0;
    localparam logic [7:0] CFG_FINAL_MIN = 8'd1;
    localparam logic [7:0] CFG_RATIO_NUM = 8'd2;
    localparam logic [7:0] CFG_RATIO_DEN = 8'd3;

    // configuration reset values
    localparam logic [7:0] RST_EARLY_MIN = 8'd10;
    localparam logic [7:0] RST_FINAL_MIN = 8'd3;
    localparam logic [3:0] RST_RATIO_NUM = 4'd3;
    localparam logic [3:0] RST_RATIO_DEN = 4'd10;

    // special bytes
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAG_OPEN  = 8'h5B;
    localparam logic [7:0] CH_TAG_CLOSE = 8'h5D;

    // lead byte masks and patterns
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'h3F;

    // cjk ranges
    localparam logic [CP_BITS-1:0] CJK_A_LO = 21'h04E00;
    localparam logic [CP_BITS-1:0] CJK_A_HI = 21'h09FFF;
    localparam logic [CP_BITS-1:0] CJK_B_LO = 21'h03400;
    localparam logic [CP_BITS-1:0] CJK_B_HI = 21'h04DBF;
    localparam logic [CP_BITS-1:0] CJK_C_LO = 21'h0F900;
    localparam logic [CP_BITS-1:0] CJK_C_HI = 21'h0FAFF;
    localparam logic [CP_BITS-1:0] CJK_D_LO = 21'h20000;
    localparam logic [CP_BITS-1:0] CJK_D_HI = 21'h2A6DF;

    // scan phase of the decoder
    typedef enum logic [1:0] {
        PH_LEAD = 2'd0,
        PH_SKIP = 2'd1,
        PH_CONT = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    // one classified code point
    typedef struct packed {
        logic valid;
        logic letter;
        logic cjk;
    } t_cls;

    // configuration registers
    typedef struct packed {
        logic [7:0] early_min;
        logic [7:0] final_min;
        logic [3:0] ratio_num;
        logic [3:0] ratio_den;
    } t_cfg;

    function automatic logic f_is_cjk(input logic [CP_BITS-1:0] cp);
        return (cp >= CJK_A_LO && cp <= CJK_A_HI) ||
               (cp >= CJK_B_LO && cp <= CJK_B_HI) ||
               (cp >= CJK_C_LO && cp <= CJK_C_HI) ||
               (cp >= CJK_D_LO && cp <= CJK_D_HI);
    endfunction

    function automatic logic f_is_ascii_letter(input logic [CP_BITS-1:0] cp);
        return (cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A);
    endfunction

    function automatic t_cls f_classify(input logic [CP_BITS-1:0] cp);
        t_cls c;
        c.valid  = 1'b1;
        c.cjk    = f_is_cjk(cp);
        c.letter = f_is_ascii_letter(cp) || c.cjk;
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/utf8cjk_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8cjk_scan
// UTF-8 byte scanner: tag skipping, sequence assembly and per-byte
// classification request for the tally stage.
// ----------------------------------------------------------------------------
module utf8cjk_scan (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_eot,
    input  wire logic              i_latch,
    output utf8cjk_pkg::t_cls      o_cls
);
    import utf8cjk_pkg::*;

    t_phase               r_phase, n_phase;
    logic [1:0]           r_pend,  n_pend;
    logic [CP_BITS-1:0]   r_part,  n_part;

    logic [CP_BITS-1:0]   w_shift;
    logic [CP_BITS-1:0]   w_cp;
    logic                 w_cp_valid;
    logic                 w_lead2, w_lead3, w_lead4;

    // shared decode terms
    assign w_shift = {r_part[CP_BITS-7:0], i_byte[5:0] & CONT_MASK[5:0]};
    assign w_lead2 = (i_byte & LEAD2_MASK) == LEAD2_PAT;
    assign w_lead3 = (i_byte & LEAD3_MASK) == LEAD3_PAT;
    assign w_lead4 = (i_byte & LEAD4_MASK) == LEAD4_PAT;

    // classification request, including a partial sequence at end of text
    always_comb begin
        w_cp_valid = 1'b0;
        w_cp       = '0;
        unique case (r_phase)
            PH_LEAD: begin
                if (i_byte == CH_NUL || i_byte == CH_TAG_OPEN) begin
                    w_cp_valid = 1'b0;
                end else if (!i_byte[7]) begin
                    w_cp_valid = 1'b1;
                    w_cp       = CP_BITS'(i_byte);
                end else if (w_lead2) begin
                    w_cp_valid = i_eot;
                    w_cp       = CP_BITS'(i_byte[4:0]);
                end else if (w_lead3) begin
                    w_cp_valid = i_eot;
                    w_cp       = CP_BITS'(i_byte[3:0]);
                end else if (w_lead4) begin
                    w_cp_valid = i_eot;
                    w_cp       = CP_BITS'(i_byte[2:0]);
                end else begin
                    w_cp_valid = 1'b1;
                    w_cp       = '0;
                end
            end
            PH_CONT: begin
                if (i_byte == CH_NUL) begin
                    w_cp_valid = 1'b1;
                    w_cp       = r_part;
                end else begin
                    w_cp_valid = (r_pend == 2'd1) || i_eot;
                    w_cp       = w_shift;
                end
            end
            PH_SKIP, PH_DONE: begin
                w_cp_valid = 1'b0;
            end
            default: begin
                w_cp_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_cls       = f_classify(w_cp);
        o_cls.valid = i_fire && w_cp_valid;
    end

    // next scan state
    always_comb begin
        n_phase = r_phase;
        n_pend  = r_pend;
        n_part  = r_part;
        unique case (r_phase)
            PH_LEAD: begin
                if (i_byte == CH_NUL) begin
                    n_phase = PH_DONE;
                end else if (i_byte == CH_TAG_OPEN) begin
                    n_phase = PH_SKIP;
                end else if (!i_byte[7]) begin
                    n_phase = PH_LEAD;
                end else if (w_lead2) begin
                    n_part  = CP_BITS'(i_byte[4:0]);
                    n_pend  = 2'd1;
                    n_phase = PH_CONT;
                end else if (w_lead3) begin
                    n_part  = CP_BITS'(i_byte[3:0]);
                    n_pend  = 2'd2;
                    n_phase = PH_CONT;
                end else if (w_lead4) begin
                    n_part  = CP_BITS'(i_byte[2:0]);
                    n_pend  = 2'd3;
                    n_phase = PH_CONT;
                end else begin
                    n_phase = PH_LEAD;
                end
            end
            PH_SKIP: begin
                if (i_byte == CH_NUL) begin
                    n_phase = PH_DONE;
                end else if (i_byte == CH_TAG_CLOSE) begin
                    n_phase = PH_LEAD;
                end
            end
            PH_CONT: begin
                if (i_byte == CH_NUL) begin
                    n_phase = PH_DONE;
                    n_pend  = 2'd0;
                end else begin
                    n_part = w_shift;
                    n_pend = r_pend - 2'd1;
                    if (r_pend == 2'd1) begin
                        n_phase = PH_LEAD;
                    end
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
        // early verdict stops the scan for the rest of the text
        if (i_latch) begin
            n_phase = PH_DONE;
        end
        // end of text returns to the start state
        if (i_eot) begin
            n_phase = PH_LEAD;
            n_pend  = 2'd0;
            n_part  = '0;
        end
    end

    // scan state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_pend  <= 2'd0;
            r_part  <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_part  <= n_part;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/utf8cjk_tally.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8cjk_tally
// Saturating letter and cjk counters, ratio test, early latch and the
// end-of-text verdict.
// ----------------------------------------------------------------------------
module utf8cjk_tally (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic              i_eot,
    input  wire utf8cjk_pkg::t_cls i_cls,
    input  wire utf8cjk_pkg::t_cfg i_cfg,
    output logic                   o_latch,
    output logic                   o_verdict
);
    import utf8cjk_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [COUNT_BITS-1:0] r_cjk, n_cjk;
    logic [COUNT_BITS-1:0] r_let, n_let;
    logic                  r_latch;

    logic                  w_inc_cjk, w_inc_let;
    logic [PROD_BITS-1:0]  w_prod_cjk, w_prod_let;
    logic [PROD_BITS-1:0]  w_lhs, w_rhs;
    logic                  w_ratio_ok;

    // saturating increments
    assign w_inc_cjk = i_cls.valid && i_cls.cjk    && (r_cjk != CNT_MAX);
    assign w_inc_let = i_cls.valid && i_cls.letter && (r_let != CNT_MAX);
    assign n_cjk     = r_cjk + COUNT_BITS'(w_inc_cjk);
    assign n_let     = r_let + COUNT_BITS'(w_inc_let);

    // ratio on the updated counts: product of the old count plus one term
    assign w_prod_cjk = PROD_BITS'(r_cjk) * PROD_BITS'(i_cfg.ratio_den);
    assign w_prod_let = PROD_BITS'(r_let) * PROD_BITS'(i_cfg.ratio_num);
    assign w_lhs      = w_prod_cjk + (w_inc_cjk ? PROD_BITS'(i_cfg.ratio_den) : '0);
    assign w_rhs      = w_prod_let + (w_inc_let ? PROD_BITS'(i_cfg.ratio_num) : '0);
    assign w_ratio_ok = w_lhs >= w_rhs;

    // early test runs after each code point
    assign o_latch = i_cls.valid && (n_let >= COUNT_BITS'(i_cfg.early_min)) && w_ratio_ok;

    // end-of-text verdict
    assign o_verdict = r_latch || o_latch ||
                       ((n_let >= COUNT_BITS'(i_cfg.final_min)) && w_ratio_ok);

    // counters and latch, cleared at end of text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cjk   <= '0;
            r_let   <= '0;
            r_latch <= 1'b0;
        end else if (i_fire) begin
            if (i_eot) begin
                r_cjk   <= '0;
                r_let   <= '0;
                r_latch <= 1'b0;
            end else begin
                r_cjk   <= n_cjk;
                r_let   <= n_let;
                r_latch <= r_latch || o_latch;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/utf8_cjk_ratio_classifier_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_cjk_ratio_classifier_top
// Classifies a UTF-8 text as Chinese or not by the share of CJK letters.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel (i_in_valid / o_in_ready) takes one text byte per request,
//    with i_end_of_text marking the last byte of a text
//  - output channel (o_out_valid / i_out_ready) gives one verdict,
//    o_is_chinese, for each byte request that carries i_end_of_text
//  - configuration channel (i_cfg_valid / o_cfg_ready) writes one register
//    per request: 0 early minimum letters, 1 final minimum letters,
//    2 ratio numerator, 3 ratio denominator; other indexes are dropped
//  - a byte lands in the input register, then the scanner and counters
//    update from it; the verdict for an ending byte is registered in the
//    result register once that byte leaves the input register
//  - throughput is one byte per cycle, except while an ending byte is
//    held back by a waiting verdict
//  - reset restores the default registers and clears all text state
//  - while a verdict waits on i_out_ready, an ending byte holds in the
//    input register and o_in_ready drops; other bytes keep flowing
// ----------------------------------------------------------------------------
module utf8_cjk_ratio_classifier_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // byte input
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_end_of_text,
    // verdict output
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_is_chinese,
    // configuration writes
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);
    import utf8cjk_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eot;
    logic       r_out_valid;
    logic       r_out_is;
    t_cfg       r_cfg;

    logic       w_fire;
    logic       w_latch;
    logic       w_verdict;
    t_cls       w_cls;

    // the held byte advances unless it ends a text and the result slot is full and not being read
    assign w_fire      = r_in_valid && (!r_in_eot || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_fire;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_is_chinese = r_out_is;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_text_byte;
            r_in_eot  <= i_end_of_text;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.early_min <= RST_EARLY_MIN;
            r_cfg.final_min <= RST_FINAL_MIN;
            r_cfg.ratio_num <= RST_RATIO_NUM;
            r_cfg.ratio_den <= RST_RATIO_DEN;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_EARLY_MIN: r_cfg.early_min <= i_cfg_data;
                CFG_FINAL_MIN: r_cfg.final_min <= i_cfg_data;
                CFG_RATIO_NUM: r_cfg.ratio_num <= i_cfg_data[3:0];
                CFG_RATIO_DEN: r_cfg.ratio_den <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // byte scanner
    utf8cjk_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (r_in_byte),
        .i_eot   (r_in_eot),
        .i_latch (w_latch),
        .o_cls   (w_cls)
    );

    // counters and decision
    utf8cjk_tally u_tally (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_eot     (r_in_eot),
        .i_cls     (w_cls),
        .i_cfg     (r_cfg),
        .o_latch   (w_latch),
        .o_verdict (w_verdict)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_eot) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_eot) begin
            r_out_is <= w_verdict;
        end
    end

`ifndef NO_ASSERTIONS
    // an ending byte that is processed always yields a verdict next cycle
    a_eot_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_in_eot |=> o_out_valid)
        else $error("ending byte processed without a verdict");

    // the verdict shown is the one computed for the ending byte
    a_verdict_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_in_eot |=> o_is_chinese == $past(w_verdict))
        else $error("verdict does not match computed decision");

    // a blocked ending byte stays in the input register
    a_eot_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in_eot && r_out_valid && !i_out_ready |=>
            r_in_valid && r_in_eot)
        else $error("blocked ending byte was lost");

    // nothing is classified without a processed byte
    a_cls_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cls.valid |-> w_fire)
        else $error("classification request without a processed byte");
`endif

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 CJK ratio classifier. Texts are streamed
// byte by byte through the input channel while a local decoder works out the
// verdict of each text. Every verdict from the block is compared in order.
// The run covers hand-picked texts, then random clean, broken and noisy
// texts under several register settings, with random stalls on both sides
// and one long output stall.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8cjk_pkg::*;

    // ascii letter bounds
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] ASCII_END  = 8'h80;

    // register indexes outside the map, writes are dropped
    localparam logic [7:0] CFG_UNUSED_LO = 8'd4;
    localparam logic [7:0] CFG_UNUSED_HI = 8'hFF;

    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 230;
    localparam int SETTLE_WAIT  = 8;
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        logic [7:0] data;
        logic       eot;
    } t_byte_req;

    // dut ports
    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_text_byte    = 8'h00;
    logic       i_end_of_text  = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready    = 1'b0;
    logic       o_is_chinese;
    logic       i_cfg_valid    = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_index    = 8'h00;
    logic [7:0] i_cfg_data     = 8'h00;

    // stimulus and expectation stores
    t_byte_req  byte_feed[$];
    logic [7:0] text_buf[$];
    bit         expected_verdicts[$];

    // decoder state mirrored from the block
    t_phase                scan_st;
    logic [1:0]            need_cnt;
    logic [CP_BITS-1:0]    code_acc;
    logic [COUNT_BITS-1:0] n_cjk;
    logic [COUNT_BITS-1:0] n_letter;
    logic                  latched;
    t_cfg                  cfg_m;

    // run control
    bit rst_done  = 1'b0;
    bit in_taken  = 1'b0;
    bit stall_req = 1'b0;
    int stall_left = 0;
    int send_idle_pct = 16;
    int recv_idle_pct = 69;

    // bookkeeping
    int n_errors    = 0;
    int n_texts_q   = 0;
    int n_items_q   = 0;
    int n_bytes     = 0;
    int n_verdicts  = 0;
    int n_chinese   = 0;
    int n_cfg_wr    = 0;
    int n_settings  = 1;

    utf8_cjk_ratio_classifier_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_is_chinese  (o_is_chinese),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("timeout with %0d verdicts still due", expected_verdicts.size());
        $display("utf8_cjk_ratio_classifier_top: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // verdict predictor
    // ------------------------------------------------------------------------

    function automatic bit is_alpha(input logic [CP_BITS-1:0] cp);
        return (cp >= CH_UPPER_A && cp <= CH_UPPER_Z) ||
               (cp >= CH_LOWER_A && cp <= CH_LOWER_Z);
    endfunction

    function automatic bit in_cjk(input logic [CP_BITS-1:0] cp);
        return (cp >= CJK_A_LO && cp <= CJK_A_HI) || (cp >= CJK_B_LO && cp <= CJK_B_HI) ||
               (cp >= CJK_C_LO && cp <= CJK_C_HI) || (cp >= CJK_D_LO && cp <= CJK_D_HI);
    endfunction

    function automatic bit share_met();
        logic [31:0] lhs;
        logic [31:0] rhs;
        lhs = 32'(n_cjk) * 32'(cfg_m.ratio_den);
        rhs = 32'(n_letter) * 32'(cfg_m.ratio_num);
        return lhs >= rhs;
    endfunction

    task automatic clear_text_state();
        scan_st  = PH_LEAD;
        need_cnt = 2'd0;
        code_acc = '0;
        n_cjk    = '0;
        n_letter = '0;
        latched  = 1'b0;
    endtask

    // count one code point, then try the early decision
    task automatic tally_code(input logic [CP_BITS-1:0] cp);
        bit letter;
        bit cjk;
        letter = 1'b0;
        cjk    = 1'b0;
        if (cp < ASCII_END)
            letter = is_alpha(cp);
        else if (in_cjk(cp)) begin
            letter = 1'b1;
            cjk    = 1'b1;
        end
        if (cjk && n_cjk != {COUNT_BITS{1'b1}})
            n_cjk = n_cjk + COUNT_BITS'(1);
        if (letter && n_letter != {COUNT_BITS{1'b1}})
            n_letter = n_letter + COUNT_BITS'(1);
        if (n_letter >= COUNT_BITS'(cfg_m.early_min) && share_met()) begin
            latched = 1'b1;
            scan_st = PH_DONE;
        end
    endtask

    // one byte through the decoder; got is set when the byte ends a text
    task automatic decode_byte(input logic [7:0] b, input logic eot,
                               output bit got, output bit verdict);
        got     = 1'b0;
        verdict = 1'b0;
        case (scan_st)
            PH_SKIP: begin
                if (b == CH_NUL)
                    scan_st = PH_DONE;
                else if (b == CH_TAG_CLOSE)
                    scan_st = PH_LEAD;
            end
            PH_CONT: begin
                if (b == CH_NUL) begin
                    scan_st  = PH_DONE;
                    need_cnt = 2'd0;
                    tally_code(code_acc);
                end else begin
                    code_acc = {code_acc[CP_BITS-7:0], b[5:0]};
                    need_cnt = need_cnt - 2'd1;
                    if (need_cnt == 2'd0) begin
                        scan_st = PH_LEAD;
                        tally_code(code_acc);
                    end
                end
            end
            PH_LEAD: begin
                if (b == CH_NUL)
                    scan_st = PH_DONE;
                else if (b == CH_TAG_OPEN)
                    scan_st = PH_SKIP;
                else if (b < ASCII_END)
                    tally_code(CP_BITS'(b));
                else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
                    code_acc = CP_BITS'(b[4:0]);
                    need_cnt = 2'd1;
                    scan_st  = PH_CONT;
                end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
                    code_acc = CP_BITS'(b[3:0]);
                    need_cnt = 2'd2;
                    scan_st  = PH_CONT;
                end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
                    code_acc = CP_BITS'(b[2:0]);
                    need_cnt = 2'd3;
                    scan_st  = PH_CONT;
                end else
                    tally_code('0);
            end
            default: ;
        endcase

        if (eot) begin
            // partial sequence is classified as it stands
            if (scan_st == PH_CONT)
                tally_code(code_acc);
            verdict = latched ||
                      (n_letter >= COUNT_BITS'(cfg_m.final_min) && share_met());
            got     = 1'b1;
            clear_text_state();
        end
    endtask

    task automatic report_mismatch(input string what);
        n_errors = n_errors + 1;
        $display("ERROR @%0t: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // byte driver
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : byte_driver
        t_byte_req nxt;
        if (!i_in_valid || in_taken) begin
            in_taken = 1'b0;
            if (rst_done && byte_feed.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                nxt = byte_feed.pop_front();
                i_in_valid    <= 1'b1;
                i_text_byte   <= nxt.data;
                i_end_of_text <= nxt.eot;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // verdict receiver, random stalls plus an optional long hold
    always @(negedge i_clk) begin : verdict_sink
        if (stall_req) begin
            stall_req  = 1'b0;
            stall_left = LONG_HOLD;
        end
        if (stall_left > 0) begin
            stall_left  = stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predict on accepted bytes, check accepted verdicts
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        bit got;
        bit verdict;
        bit want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                in_taken = 1'b1;
                n_bytes  = n_bytes + 1;
                decode_byte(i_text_byte, i_end_of_text, got, verdict);
                if (got)
                    expected_verdicts.insert(expected_verdicts.size(), verdict);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("verdict %0b with no text pending",
                                              o_is_chinese));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (o_is_chinese !== want)
                        report_mismatch($sformatf("text %0d: is_chinese %0b, expected %0b",
                                                  n_verdicts, o_is_chinese, want));
                    n_verdicts = n_verdicts + 1;
                    if (want)
                        n_chinese = n_chinese + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // register writes
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_EARLY_MIN: cfg_m.early_min = val;
            CFG_FINAL_MIN: cfg_m.final_min = val;
            CFG_RATIO_NUM: cfg_m.ratio_num = val[3:0];
            CFG_RATIO_DEN: cfg_m.ratio_den = val[3:0];
            default: ;
        endcase
        n_cfg_wr = n_cfg_wr + 1;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input int ph);
        case (ph)
            0: ;
            1: begin
                write_reg(CFG_EARLY_MIN, 8'd0);
                write_reg(CFG_FINAL_MIN, 8'd0);
                write_reg(CFG_RATIO_NUM, 8'd0);
                write_reg(CFG_RATIO_DEN, 8'd0);
                write_reg(CFG_UNUSED_HI, 8'hA5);
            end
            2: begin
                write_reg(CFG_EARLY_MIN, 8'hFF);
                write_reg(CFG_FINAL_MIN, 8'hFF);
                write_reg(CFG_RATIO_NUM, 8'hFF);
                write_reg(CFG_RATIO_DEN, 8'hFF);
            end
            3: begin
                write_reg(CFG_EARLY_MIN, 8'd1);
                write_reg(CFG_FINAL_MIN, 8'd0);
                write_reg(CFG_RATIO_NUM, 8'd1);
                write_reg(CFG_RATIO_DEN, 8'd1);
                write_reg(CFG_UNUSED_LO, 8'h5A);
            end
            default: begin
                write_reg(CFG_EARLY_MIN, ($urandom_range(9) == 0) ?
                          8'($urandom) : 8'($urandom_range(20)));
                write_reg(CFG_FINAL_MIN, 8'($urandom_range(12)));
                write_reg(CFG_RATIO_NUM, 8'($urandom));
                write_reg(CFG_RATIO_DEN, 8'($urandom));
                if ($urandom_range(1) == 1)
                    write_reg(8'($urandom_range(255, CFG_UNUSED_LO)), 8'($urandom));
            end
        endcase
        if (ph != 0)
            n_settings = n_settings + 1;
    endtask

    // ------------------------------------------------------------------------
    // text builders
    // ------------------------------------------------------------------------

    // append one byte to the text being built
    task automatic add_byte(input logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endtask

    // queue the buffered text, end flag on its last byte
    task automatic close_text();
        t_byte_req r;
        if (text_buf.size() == 0)
            add_byte(CH_UPPER_A);
        foreach (text_buf[i]) begin
            r.data = text_buf[i];
            r.eot  = (i == text_buf.size() - 1);
            byte_feed.insert(byte_feed.size(), r);
        end
        n_items_q = n_items_q + text_buf.size();
        n_texts_q = n_texts_q + 1;
        text_buf.delete();
    endtask

    task automatic put_cp(input logic [CP_BITS-1:0] cp);
        if (cp < 21'h80) begin
            add_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            add_byte({3'b110, cp[10:6]});
            add_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            add_byte({4'b1110, cp[15:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
        end else begin
            add_byte({5'b11110, cp[20:18]});
            add_byte({2'b10, cp[17:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
        end
    endtask

    function automatic logic [CP_BITS-1:0] pick_cjk();
        case ($urandom_range(5))
            0: return CP_BITS'($urandom_range(CJK_A_HI, CJK_A_LO));
            1: return CP_BITS'($urandom_range(CJK_B_HI, CJK_B_LO));
            2: return CP_BITS'($urandom_range(CJK_C_HI, CJK_C_LO));
            3: return CP_BITS'($urandom_range(CJK_D_HI, CJK_D_LO));
            4: return CP_BITS'($urandom_range(CJK_A_HI, CJK_A_LO));
            default: begin
                // range edges
                case ($urandom_range(7))
                    0: return CJK_A_LO;
                    1: return CJK_A_HI;
                    2: return CJK_B_LO;
                    3: return CJK_B_HI;
                    4: return CJK_C_LO;
                    5: return CJK_C_HI;
                    6: return CJK_D_LO;
                    default: return CJK_D_HI;
                endcase
            end
        endcase
    endfunction

    // code points above ascii, mostly non-cjk, and just outside each range
    function automatic logic [CP_BITS-1:0] pick_other();
        case ($urandom_range(6))
            0: return CP_BITS'($urandom_range(21'h7FF, 21'h80));
            1: return CP_BITS'($urandom_range(21'h33FF, 21'h3000));
            2: return CP_BITS'($urandom_range(21'hD7A3, 21'hAC00));
            3: return CP_BITS'($urandom_range(21'h1FFFFF, 21'h10000));
            4: return CP_BITS'($urandom_range(21'h4DFF, 21'h4DC0));
            default: begin
                case ($urandom_range(5))
                    0: return CJK_A_HI + CP_BITS'(1);
                    1: return CJK_B_LO - CP_BITS'(1);
                    2: return CJK_C_LO - CP_BITS'(1);
                    3: return CJK_C_HI + CP_BITS'(1);
                    4: return CJK_D_LO - CP_BITS'(1);
                    default: return CJK_D_HI + CP_BITS'(1);
                endcase
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_letter();
        logic [7:0] c;
        case ($urandom_range(5))
            0: c = CH_UPPER_A;
            1: c = CH_LOWER_Z;
            2: c = 8'($urandom_range(CH_UPPER_Z, CH_UPPER_A));
            default: c = 8'($urandom_range(CH_LOWER_Z, CH_LOWER_A));
        endcase
        return c;
    endfunction

    // printable or control ascii that is neither a letter nor a tag opener
    function automatic logic [7:0] pick_symbol();
        logic [7:0] c;
        do c = 8'($urandom_range(127, 1));
        while (c == CH_TAG_OPEN || is_alpha(CP_BITS'(c)));
        return c;
    endfunction

    task automatic put_tag();
        int len;
        logic [7:0] c;
        len = $urandom_range(6);
        add_byte(CH_TAG_OPEN);
        repeat (len) begin
            do c = 8'($urandom_range(255, 1));
            while (c == CH_TAG_CLOSE);
            add_byte(c);
        end
        add_byte(CH_TAG_CLOSE);
    endtask

    // well-formed text body with a given share of cjk letters
    task automatic put_clean(input int n, input int cjk_pct);
        int r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 8)
                put_tag();
            else if (r < 20)
                add_byte(pick_symbol());
            else if (r < 28)
                put_cp(pick_other());
            else if ($urandom_range(99) < cjk_pct)
                put_cp(pick_cjk());
            else
                add_byte(pick_letter());
        end
    endtask

    task automatic gen_text();
        int kind;
        int n;
        int need;
        kind = $urandom_range(99);
        n = ($urandom_range(19) == 0) ? $urandom_range(150, 40) : $urandom_range(24, 1);
        if (kind < 65) begin
            put_clean(n, $urandom_range(100));
        end else if (kind < 88) begin
            // well-formed start, then a defect
            put_clean($urandom_range(10), $urandom_range(100));
            case ($urandom_range(4))
                0: begin
                    // text ends mid-sequence
                    need = $urandom_range(3, 1);
                    add_byte(need == 1 ? 8'($urandom_range(8'hDF, 8'hC0)) :
                             need == 2 ? 8'($urandom_range(8'hEF, 8'hE0)) :
                                         8'($urandom_range(8'hF7, 8'hF0)));
                    repeat ($urandom_range(need - 1))
                        add_byte(8'($urandom_range(8'hBF, 8'h80)));
                end
                1: begin
                    // zero byte, maybe inside a sequence, then leftovers
                    if ($urandom_range(1) == 1) begin
                        add_byte(8'($urandom_range(8'hF7, 8'hC0)));
                        if ($urandom_range(1) == 1)
                            add_byte(8'($urandom_range(8'hBF, 8'h80)));
                    end
                    add_byte(CH_NUL);
                    repeat ($urandom_range(4))
                        add_byte(8'($urandom));
                end
                2: begin
                    // stray following bytes or invalid leads
                    repeat ($urandom_range(4, 1))
                        add_byte(($urandom_range(1) == 1) ?
                                 8'($urandom_range(8'hBF, 8'h80)) :
                                 8'($urandom_range(8'hFF, 8'hF8)));
                    put_clean($urandom_range(4), 50);
                end
                3: begin
                    // tag never closed
                    add_byte(CH_TAG_OPEN);
                    repeat ($urandom_range(5))
                        add_byte(pick_letter());
                end
                default: begin
                    // following bytes taken without any check
                    add_byte(8'($urandom_range(8'hF7, 8'hC0)));
                    repeat ($urandom_range(3, 1))
                        add_byte(8'($urandom_range(255, 1)));
                    put_clean($urandom_range(4), 50);
                end
            endcase
        end else begin
            // raw noise
            repeat ($urandom_range(12, 1))
                add_byte(8'($urandom));
        end
        close_text();
    endtask

    // wait until every byte is taken and every verdict is back
    task automatic wait_idle();
        while (byte_feed.size() != 0 || i_in_valid || expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int target;
        clear_text_state();
        cfg_m.early_min = RST_EARLY_MIN;
        cfg_m.final_min = RST_FINAL_MIN;
        cfg_m.ratio_num = RST_RATIO_NUM;
        cfg_m.ratio_den = RST_RATIO_DEN;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;

        // letter bounds only, no cjk
        add_byte(CH_UPPER_A);
        add_byte(CH_UPPER_Z);
        add_byte(CH_LOWER_A);
        add_byte(CH_LOWER_Z);
        close_text();
        // three cjk forms around a skipped tag
        put_cp(CJK_A_LO);
        add_byte(CH_TAG_OPEN);
        add_byte(CH_AT);
        add_byte(CH_TAG_CLOSE);
        put_cp(CJK_D_LO);
        put_cp(CJK_B_LO);
        close_text();
        // invalid lead byte alone
        add_byte(8'hFF);
        close_text();
        // text cut inside a three byte sequence
        add_byte(8'hE4);
        add_byte(8'hB8);
        close_text();
        // zero byte stops the scan
        add_byte(CH_UPPER_A);
        add_byte(CH_NUL);
        add_byte(CH_UPPER_A);
        close_text();
        // text ends inside a tag
        add_byte(CH_TAG_OPEN);
        add_byte(CH_UPPER_A);
        close_text();

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            wait_idle();
            if (ph < 3) begin
                send_idle_pct = 16;
                recv_idle_pct = 69;
            end else if (ph < 6) begin
                send_idle_pct = 69;
                recv_idle_pct = 16;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_setting(ph);
            target = n_items_q + PHASE_ITEMS;
            while (n_items_q < target)
                gen_text();
            // long output stall while bytes keep coming
            if (ph == 1)
                stall_req = 1'b1;
        end
        wait_idle();

        $display("%0d texts in %0d bytes judged, %0d Chinese and %0d not",
                 n_verdicts, n_bytes, n_chinese, n_verdicts - n_chinese);
        $display("%0d register writes over %0d settings, %0d mismatches",
                 n_cfg_wr, n_settings, n_errors);
        if (n_errors == 0)
            $display("utf8_cjk_ratio_classifier_top: match");
        else
            $display("utf8_cjk_ratio_classifier_top: mismatch");
        $finish;
    end

endmodule
